@@ rtl/pbp_pkg.sv @@
package pbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int CODE_WORD_W = 32;
  localparam int CODE_LEN_W  = 6;
  localparam int SYMBOL_W    = 8;
  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int PEND_W      = 7;
  localparam int PEND_CNT_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ENCODE,
    ST_FLUSH
  } state_t;

endpackage

@@ rtl/pbp_ram.sv @@
module pbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/prefix_code_bit_packer_top.sv @@
// steps: a load writes the table on accept; a flush registers the padded byte; an encode
// runs accept, table read, one byte a cycle while the output is free, and a closing step
// throughput: one item at a time; the single-port code table read and the one-byte-a-cycle
// output register, held while out_tready is low, set the pace
// reset: synchronous active-low rst_n clears the pending bits, the table valid bits
// (so every entry reads as length zero) and the output valid flag; no clearing sweep
module prefix_code_bit_packer_top
  import pbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // symbol [7:0], code_word [39:8], code_length [45:40], zero pad [47:46]
  input  logic [47:0] in_tdata,
  // command [1:0]
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte [7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  // stored length must hold MAX_CODE_LEN itself
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int SYM_W  = $clog2(SYMBOL_COUNT);
  localparam int DATA_W = CODE_WORD_W + LEN_W;

  // input field split
  cmd_t                   in_cmd;
  logic [SYMBOL_W-1:0]    in_sym;
  logic [CODE_WORD_W-1:0] in_word;
  logic [CODE_LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]       len_clamp;
  logic [SYM_W-1:0]       sym_idx;
  logic                   sym_ok;
  logic                   accept;

  assign in_cmd  = cmd_t'(in_tuser);
  assign in_sym  = in_tdata[SYMBOL_W-1:0];
  assign in_word = in_tdata[SYMBOL_W +: CODE_WORD_W];
  assign in_len  = in_tdata[SYMBOL_W + CODE_WORD_W +: CODE_LEN_W];
  assign sym_idx = in_sym[SYM_W-1:0];
  assign sym_ok  = (int'(in_sym) < SYMBOL_COUNT);

  // long codes are cut to the longest length the table holds
  always_comb begin
    if (int'(in_len) > MAX_CODE_LEN) begin
      len_clamp = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_clamp = LEN_W'(in_len);
    end
  end

  // control and working registers
  state_t                 state_r, state_nxt;
  logic [PEND_W-1:0]      pend_bits_r, pend_bits_nxt;
  logic [PEND_CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [SYMBOL_COUNT-1:0] vld_r, vld_nxt;
  logic                   rd_vld_r;
  logic [CODE_WORD_W-1:0] cw_r, cw_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]      out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  // code table memory: {length, code word} per symbol
  logic              ram_en;
  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;

  pbp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (sym_idx),
    .wdata ({len_clamp, in_word}),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // byte assembly datapath
  logic                   slot_free;
  logic [3:0]             need;
  logic [LEN_W:0]         fill_sum;
  logic                   full_byte;
  logic [LEN_W-1:0]       shamt;
  logic [CODE_WORD_W-1:0] cw_sh;
  logic [BYTE_W-1:0]      need_mask;
  logic [15:0]            acc_w;
  logic [BYTE_W-1:0]      enc_byte;
  logic [PEND_CNT_W-1:0]  rem_lo;
  logic [15:0]            left_w;
  logic [BYTE_W-1:0]      rem_mask;

  // output register can take a new byte this cycle
  assign slot_free = !out_valid_r || out_tready;

  // bits still missing from the current byte, 1..8
  assign need      = 4'(BYTE_W) - {1'b0, pend_cnt_r};
  assign fill_sum  = (LEN_W+1)'(rem_r) + (LEN_W+1)'(pend_cnt_r);
  assign full_byte = (fill_sum >= (LEN_W+1)'(BYTE_W));

  // code bits taken next sit at rem-1 down to rem-need; positions past the word read zero
  assign shamt     = rem_r - LEN_W'(need);
  assign cw_sh     = cw_r >> shamt;
  assign need_mask = BYTE_W'((9'h1 << need) - 9'h1);
  assign acc_w     = {9'b0, pend_bits_r} << need;
  assign enc_byte  = acc_w[BYTE_W-1:0] | (cw_sh[BYTE_W-1:0] & need_mask);

  // tail of a code shorter than the missing bits, below eight in that case
  assign rem_lo    = rem_r[PEND_CNT_W-1:0];
  assign left_w    = {9'b0, pend_bits_r} << rem_lo;
  assign rem_mask  = BYTE_W'((9'h1 << rem_lo) - 9'h1);

  always_comb begin
    state_nxt     = state_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    vld_nxt       = vld_r;
    cw_nxt        = cw_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LOAD: begin
              if (sym_ok) begin
                ram_en           = 1'b1;
                ram_we           = 1'b1;
                vld_nxt[sym_idx] = 1'b1;
              end
            end
            CMD_ENCODE: begin
              // an out-of-range symbol acts as an empty code
              if (sym_ok) begin
                ram_en    = 1'b1;
                state_nxt = ST_LOOKUP;
              end
            end
            CMD_FLUSH: begin
              if (pend_cnt_r != '0) begin
                state_nxt = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        // never-loaded entries read as length zero
        if (rd_vld_r) begin
          cw_nxt  = ram_rdata[CODE_WORD_W-1:0];
          rem_nxt = ram_rdata[CODE_WORD_W +: LEN_W];
        end else begin
          cw_nxt  = '0;
          rem_nxt = '0;
        end
        state_nxt = ST_ENCODE;
      end

      ST_ENCODE: begin
        if (full_byte) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = enc_byte;
            out_last_nxt  = (shamt < LEN_W'(BYTE_W));
            rem_nxt       = shamt;
            pend_bits_nxt = '0;
            pend_cnt_nxt  = '0;
          end
        end else begin
          pend_bits_nxt = left_w[PEND_W-1:0] | (cw_r[PEND_W-1:0] & rem_mask[PEND_W-1:0]);
          pend_cnt_nxt  = pend_cnt_r + rem_lo;
          rem_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        // pending bits left-aligned, zero padded
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_w[BYTE_W-1:0];
          out_last_nxt  = 1'b1;
          pend_bits_nxt = '0;
          pend_cnt_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_vld_r   <= vld_r[sym_idx];
    cw_r       <= cw_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule
